/* hw/rtl/gpsconv_pkg.sv */
// Package for the timestamp converter: operation codes, calendar constants and
// the reciprocals used for constant division. No dependencies.

package gpsconv_pkg;

    typedef enum logic [1:0] {
        OP_YD2MJD   = 2'd0,
        OP_MJD2YD   = 2'd1,
        OP_MJD2UNIX = 2'd2,
        OP_UNIX2MJD = 2'd3
    } op_t;

    localparam int unsigned DAYS_PER_4Y   = 1461;
    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned MJD_UNIX_EPOCH = 40587;
    localparam int unsigned MJD_YEAR_OFS  = 678960;
    localparam int unsigned LIN_YEAR_OFS  = 4799;
    localparam int unsigned CENT_YEAR_OFS = 4899;
    localparam int unsigned YEAR_BASE     = 2431739;
    localparam int unsigned MJD_MAX       = 4194303;

    // Low seven bits of a Unix time split off the factor 128 of 86400.
    localparam int unsigned SECS_SHIFT = 7;
    localparam int unsigned SECS_ODD   = SECS_PER_DAY >> SECS_SHIFT;

    // Truncated reciprocals: the quotient estimate may be one low.
    localparam int unsigned RECIP_1461_SH = 36;
    localparam logic [25:0] RECIP_1461 = 26'((64'd1 << RECIP_1461_SH) / 64'd1461);
    localparam int unsigned RECIP_675_SH = 32;
    localparam logic [22:0] RECIP_675 = 23'((64'd1 << RECIP_675_SH) / 64'd675);

    // Rounded-up reciprocal of 100, exact for every 15-bit numerator.
    localparam int unsigned RECIP_100_SH = 22;
    localparam logic [15:0] RECIP_100 = 16'(((64'd1 << RECIP_100_SH) + 64'd99) / 64'd100);

endpackage

/* hw/rtl/gps_year_day_mjd_unix_converter.sv */
// Top level of the timestamp converter: a five-stage pipeline for the four
// conversions. Depends on gpsconv_pkg.

// Usage: a request is taken on every cycle in which start is high; busy is
// always low, so a new beat may follow in the very next cycle. Each request
// yields exactly one result, shown for one cycle with done high, in request
// order, after it has passed stages 1 to 4 and the output stage. The receiver
// cannot hold results off, so it must take every beat on the cycle that done
// marks it. The stages hold the chain of constant multiplies: a reciprocal
// quotient estimate, its correction, the year-start products and their
// combination, then the final selection. Fields that an operation does not
// produce are zero, and every field is zero when valid_res is low.
module gps_year_day_mjd_unix_converter
    import gpsconv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [13:0]        gps_year,
    input  logic [8:0]         gps_day,
    input  logic [21:0]        mjd_in,
    input  logic [16:0]        day_secs_in,
    input  logic [37:0]        unix_in,
    output logic               done,
    output logic               valid_res,
    output logic [21:0]        mjd_out,
    output logic [13:0]        year_out,
    output logic [8:0]         day_out,
    output logic signed [39:0] unix_out,
    output logic [16:0]        day_secs_out
);

    // 1461 * (y + 4799), the first term of the year start.
    function automatic logic [25:0] ys_lin(input logic [13:0] y);
        logic [25:0] n;
        n = 26'(15'(y) + 15'(LIN_YEAR_OFS));
        return n * 26'(DAYS_PER_4Y);
    endfunction

    // floor((y + 4899) / 100) by reciprocal multiplication.
    function automatic logic [7:0] ys_cent(input logic [13:0] y);
        logic [30:0] p;
        p = 31'(15'(y) + 15'(CENT_YEAR_OFS)) * 31'(RECIP_100);
        return p[RECIP_100_SH +: 8];
    endfunction

    // MJD of January 1 from the two registered products.
    function automatic logic signed [24:0] ys_finish(input logic [25:0] a, input logic [7:0] c);
        logic [9:0]         b;
        logic signed [24:0] s;
        b = (10'(c) * 10'd3) >> 2;
        s = $signed({1'b0, a[25:2]}) - $signed(25'(b)) - $signed(25'(YEAR_BASE));
        return s;
    endfunction

    op_t in_op;
    logic in_ok;
    logic [24:0] n1;
    logic [50:0] p1;
    logic [30:0] q1;
    logic [53:0] p3;
    logic signed [22:0] mjd_rel;
    logic signed [40:0] mjd_rel_ext;

    // Stage 1: quotient estimates and the Unix product.
    logic               s1_vld_reg;
    op_t                s1_op_reg;
    logic               s1_ok_reg;
    logic [13:0]        s1_year_reg;
    logic [8:0]         s1_day_reg;
    logic [21:0]        s1_mjd_reg;
    logic [16:0]        s1_secs_reg;
    logic [24:0]        s1_n_reg;
    logic [13:0]        s1_qy_reg;
    logic [30:0]        s1_q_reg;
    logic [21:0]        s1_qd_reg;
    logic [6:0]         s1_r7_reg;
    logic signed [40:0] s1_prod_reg;

    // Stage 2: corrected quotients.
    logic               s2_vld_reg;
    op_t                s2_op_reg;
    logic               s2_ok_reg;
    logic [13:0]        s2_year_reg;
    logic [8:0]         s2_day_reg;
    logic [21:0]        s2_mjd_reg;
    logic [21:0]        s2_umjd_reg;
    logic [16:0]        s2_usecs_reg;
    logic signed [39:0] s2_unix_reg;

    // Stage 3: year-start products for the year and the year before.
    logic               s3_vld_reg;
    op_t                s3_op_reg;
    logic               s3_ok_reg;
    logic [13:0]        s3_year_reg;
    logic [8:0]         s3_day_reg;
    logic [21:0]        s3_mjd_reg;
    logic [21:0]        s3_umjd_reg;
    logic [16:0]        s3_usecs_reg;
    logic signed [39:0] s3_unix_reg;
    logic [25:0]        s3_ay_reg;
    logic [7:0]         s3_cy_reg;
    logic [25:0]        s3_am_reg;
    logic [7:0]         s3_cm_reg;

    // Stage 4: year starts.
    logic               s4_vld_reg;
    op_t                s4_op_reg;
    logic               s4_ok_reg;
    logic [13:0]        s4_year_reg;
    logic [8:0]         s4_day_reg;
    logic [21:0]        s4_mjd_reg;
    logic [21:0]        s4_umjd_reg;
    logic [16:0]        s4_usecs_reg;
    logic signed [39:0] s4_unix_reg;
    logic signed [24:0] s4_sy_reg;
    logic signed [24:0] s4_sm_reg;

    // Output stage.
    logic               done_reg;
    logic               valid_res_reg;
    logic [21:0]        mjd_out_reg;
    logic [13:0]        year_out_reg;
    logic [8:0]         day_out_reg;
    logic signed [39:0] unix_out_reg;
    logic [16:0]        day_secs_out_reg;

    logic               valid_res_next;
    logic [21:0]        mjd_out_next;
    logic [13:0]        year_out_next;
    logic [8:0]         day_out_next;
    logic signed [39:0] unix_out_next;
    logic [16:0]        day_secs_out_next;

    logic [24:0] r1;
    logic [13:0] y_fix;
    logic [30:0] r3;
    logic [21:0] qd_fix;
    logic [9:0]  r3_fix;
    logic [13:0] y_prev;
    logic signed [24:0] m0;
    logic signed [24:0] mjd_s;
    logic        step_back;
    logic signed [24:0] s_sel;
    logic signed [24:0] doy;

    assign busy = 1'b0;
    assign in_op = op_t'(op);

    // Stage 1 arithmetic.
    always_comb
    begin
        case (in_op)
            OP_YD2MJD:   in_ok = (gps_year != 14'd0) && (gps_day != 9'd0);
            OP_MJD2YD:   in_ok = (mjd_in != 22'd0);
            OP_MJD2UNIX: in_ok = (mjd_in != 22'd0) && (day_secs_in != 17'd0);
            OP_UNIX2MJD: in_ok = (unix_in != 38'd0);
            default:     in_ok = 1'b0;
        endcase
        n1 = {23'(mjd_in) + 23'(MJD_YEAR_OFS), 2'b00};
        p1 = 51'(n1) * 51'(RECIP_1461);
        q1 = unix_in[37:SECS_SHIFT];
        p3 = 54'(q1) * 54'(RECIP_675);
        mjd_rel = $signed({1'b0, mjd_in}) - $signed(23'(MJD_UNIX_EPOCH));
        mjd_rel_ext = 41'(mjd_rel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= start && !busy;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            done_reg   <= s4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_op_reg   <= in_op;
        s1_ok_reg   <= in_ok;
        s1_year_reg <= gps_year;
        s1_day_reg  <= gps_day;
        s1_mjd_reg  <= mjd_in;
        s1_secs_reg <= day_secs_in;
        s1_n_reg    <= n1;
        s1_qy_reg   <= p1[RECIP_1461_SH +: 14];
        s1_q_reg    <= q1;
        s1_qd_reg   <= p3[RECIP_675_SH +: 22];
        s1_r7_reg   <= unix_in[SECS_SHIFT-1:0];
        s1_prod_reg <= mjd_rel_ext * $signed(41'(SECS_PER_DAY));
    end

    // Stage 2: each estimate is at most one low, so one compare fixes it.
    always_comb
    begin
        r1 = s1_n_reg - 25'(s1_qy_reg) * 25'(DAYS_PER_4Y);
        y_fix = s1_qy_reg + 14'(r1 >= 25'(DAYS_PER_4Y));
        r3 = s1_q_reg - 31'(s1_qd_reg) * 31'(SECS_ODD);
        if (r3 >= 31'(SECS_ODD))
        begin
            qd_fix = s1_qd_reg + 22'd1;
            r3_fix = 10'(r3 - 31'(SECS_ODD));
        end
        else
        begin
            qd_fix = s1_qd_reg;
            r3_fix = 10'(r3);
        end
    end

    always_ff @(posedge clk)
    begin
        s2_op_reg    <= s1_op_reg;
        s2_ok_reg    <= s1_ok_reg;
        s2_year_reg  <= (s1_op_reg == OP_YD2MJD) ? s1_year_reg : y_fix;
        s2_day_reg   <= s1_day_reg;
        s2_mjd_reg   <= s1_mjd_reg;
        s2_umjd_reg  <= qd_fix + 22'(MJD_UNIX_EPOCH);
        s2_usecs_reg <= {r3_fix, s1_r7_reg};
        s2_unix_reg  <= 40'(s1_prod_reg + $signed(41'(s1_secs_reg)));
    end

    // Stage 3: the year before is needed when the year estimate was one high.
    assign y_prev = s2_year_reg - 14'd1;

    always_ff @(posedge clk)
    begin
        s3_op_reg    <= s2_op_reg;
        s3_ok_reg    <= s2_ok_reg;
        s3_year_reg  <= s2_year_reg;
        s3_day_reg   <= s2_day_reg;
        s3_mjd_reg   <= s2_mjd_reg;
        s3_umjd_reg  <= s2_umjd_reg;
        s3_usecs_reg <= s2_usecs_reg;
        s3_unix_reg  <= s2_unix_reg;
        s3_ay_reg    <= ys_lin(s2_year_reg);
        s3_cy_reg    <= ys_cent(s2_year_reg);
        s3_am_reg    <= ys_lin(y_prev);
        s3_cm_reg    <= ys_cent(y_prev);
    end

    // Stage 4.
    always_ff @(posedge clk)
    begin
        s4_op_reg    <= s3_op_reg;
        s4_ok_reg    <= s3_ok_reg;
        s4_year_reg  <= s3_year_reg;
        s4_day_reg   <= s3_day_reg;
        s4_mjd_reg   <= s3_mjd_reg;
        s4_umjd_reg  <= s3_umjd_reg;
        s4_usecs_reg <= s3_usecs_reg;
        s4_unix_reg  <= s3_unix_reg;
        s4_sy_reg    <= ys_finish(s3_ay_reg, s3_cy_reg);
        s4_sm_reg    <= ys_finish(s3_am_reg, s3_cm_reg);
    end

    // Stage 5: range check, year correction and result selection.
    always_comb
    begin
        m0 = s4_sy_reg + $signed(25'(s4_day_reg)) - 25'sd1;
        mjd_s = $signed(25'(s4_mjd_reg));
        step_back = (s4_sy_reg > mjd_s);
        s_sel = step_back ? s4_sm_reg : s4_sy_reg;
        doy = mjd_s - s_sel + 25'sd1;

        valid_res_next    = 1'b0;
        mjd_out_next      = 22'd0;
        year_out_next     = 14'd0;
        day_out_next      = 9'd0;
        unix_out_next     = 40'sd0;
        day_secs_out_next = 17'd0;
        if (s4_ok_reg)
        begin
            case (s4_op_reg)
                OP_YD2MJD:
                begin
                    if (!m0[24] && (m0 <= $signed(25'(MJD_MAX))))
                    begin
                        valid_res_next = 1'b1;
                        mjd_out_next   = m0[21:0];
                    end
                end
                OP_MJD2YD:
                begin
                    valid_res_next = 1'b1;
                    year_out_next  = step_back ? (s4_year_reg - 14'd1) : s4_year_reg;
                    day_out_next   = doy[8:0];
                end
                OP_MJD2UNIX:
                begin
                    valid_res_next = 1'b1;
                    unix_out_next  = s4_unix_reg;
                end
                OP_UNIX2MJD:
                begin
                    valid_res_next    = 1'b1;
                    mjd_out_next      = s4_umjd_reg;
                    day_secs_out_next = s4_usecs_reg;
                end
                default:
                begin
                    valid_res_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        valid_res_reg    <= valid_res_next;
        mjd_out_reg      <= mjd_out_next;
        year_out_reg     <= year_out_next;
        day_out_reg      <= day_out_next;
        unix_out_reg     <= unix_out_next;
        day_secs_out_reg <= day_secs_out_next;
    end

    assign done         = done_reg;
    assign valid_res    = valid_res_reg;
    assign mjd_out      = mjd_out_reg;
    assign year_out     = year_out_reg;
    assign day_out      = day_out_reg;
    assign unix_out     = unix_out_reg;
    assign day_secs_out = day_secs_out_reg;

endmodule

/* verif/gps_year_day_mjd_unix_converter_tb.sv */
// Self-checking testbench for the timestamp converter: directed and random
// conversion requests, with an in-bench predictor and an in-order result check.
// Depends on gpsconv_pkg and gps_year_day_mjd_unix_converter.

module gps_year_day_mjd_unix_converter_tb;
    import gpsconv_pkg::*;

    localparam int  NUM_RANDOM   = 850;
    localparam int  QUIET_TAIL   = 150;
    localparam int  STALL_LIMIT  = 500;
    localparam int  DRAIN_CYCLES = 10;
    localparam longint MJD_TOP   = longint'(MJD_MAX);
    localparam longint DAY_SECS  = longint'(SECS_PER_DAY);
    localparam longint UNIX_MJD  = longint'(MJD_UNIX_EPOCH);

    typedef struct packed {
        op_t         op;
        logic [13:0] year;
        logic [8:0]  day;
        logic [21:0] mjd;
        logic [16:0] secs;
        logic [37:0] unix;
    } conv_req_t;

    typedef struct packed {
        logic               valid;
        logic [21:0]        mjd;
        logic [13:0]        year;
        logic [8:0]         day;
        logic signed [39:0] unix;
        logic [16:0]        secs;
    } conv_res_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start;
    logic               busy;
    logic [1:0]         op;
    logic [13:0]        gps_year;
    logic [8:0]         gps_day;
    logic [21:0]        mjd_in;
    logic [16:0]        day_secs_in;
    logic [37:0]        unix_in;
    logic               done;
    logic               valid_res;
    logic [21:0]        mjd_out;
    logic [13:0]        year_out;
    logic [8:0]         day_out;
    logic signed [39:0] unix_out;
    logic [16:0]        day_secs_out;

    conv_req_t pending_requests[$];
    conv_res_t awaited_results[$];
    int        total_items = 0;
    int        issued = 0;
    int        accepted_cnt = 0;
    int        gap_left = 0;
    int        stall_cycles = 0;
    int        errors = 0;
    logic      beat_taken = 1'b0;

    gps_year_day_mjd_unix_converter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .gps_year     (gps_year),
        .gps_day      (gps_day),
        .mjd_in       (mjd_in),
        .day_secs_in  (day_secs_in),
        .unix_in      (unix_in),
        .done         (done),
        .valid_res    (valid_res),
        .mjd_out      (mjd_out),
        .year_out     (year_out),
        .day_out      (day_out),
        .unix_out     (unix_out),
        .day_secs_out (day_secs_out)
    );

    always #6 clk = ~clk;

    // MJD of January 1 of year y, Gregorian calendar.
    function automatic longint first_mjd_of_year(longint y);
        longint a;
        longint b;
        a = (1461 * (y + 4799)) / 4;
        b = (3 * ((y + 4899) / 100)) / 4;
        return a - b - 2431739;
    endfunction

    function automatic conv_res_t convert_timestamp(conv_req_t r);
        conv_res_t         res;
        longint            m;
        longint            y;
        longint            s;
        longint            d;
        longint            u;
        longint unsigned   ux;
        longint unsigned   q;
        res = '0;
        m = longint'(r.mjd);
        case (r.op)
            OP_YD2MJD:
            begin
                if (r.year != 0 && r.day != 0)
                begin
                    s = first_mjd_of_year(longint'(r.year)) + longint'(r.day) - 1;
                    if (s >= 0 && s <= MJD_TOP)
                    begin
                        res.valid = 1'b1;
                        res.mjd = s[21:0];
                    end
                end
            end
            OP_MJD2YD:
            begin
                if (r.mjd != 0)
                begin
                    // The year estimate can be one high; step back once if so.
                    y = (4 * (m + 678960)) / 1461;
                    s = first_mjd_of_year(y);
                    if (s > m)
                    begin
                        y = y - 1;
                        s = first_mjd_of_year(y);
                    end
                    d = m - s + 1;
                    res.valid = 1'b1;
                    res.year = y[13:0];
                    res.day = d[8:0];
                end
            end
            OP_MJD2UNIX:
            begin
                if (r.mjd != 0 && r.secs != 0)
                begin
                    u = (m - UNIX_MJD) * DAY_SECS + longint'(r.secs);
                    res.valid = 1'b1;
                    res.unix = u[39:0];
                end
            end
            default:
            begin
                if (r.unix != 0)
                begin
                    ux = longint'(r.unix);
                    q = ux / 64'd86400 + 64'd40587;
                    res.valid = 1'b1;
                    res.mjd = q[21:0];
                    res.secs = 17'(ux % 64'd86400);
                end
            end
        endcase
        return res;
    endfunction

    function automatic void add_request(op_t o, logic [13:0] y, logic [8:0] d,
                                        logic [21:0] m, logic [16:0] s,
                                        logic [37:0] u);
        conv_req_t r;
        r.op = o;
        r.year = y;
        r.day = d;
        r.mjd = m;
        r.secs = s;
        r.unix = u;
        pending_requests.push_back(r);
    endfunction

    function automatic logic [37:0] rand_unix();
        return {6'($urandom_range(0, 63)), 32'($urandom)};
    endfunction

    function automatic void add_random_request();
        conv_req_t r;
        r.op = op_t'($urandom_range(0, 3));
        r.year = 14'($urandom);
        r.day = 9'($urandom);
        r.mjd = 22'($urandom);
        r.secs = 17'($urandom);
        r.unix = rand_unix();
        case (r.op)
            OP_YD2MJD:
            begin
                // Mostly years and days whose MJD lands in range.
                if ($urandom_range(0, 3) != 0)
                    r.year = 14'($urandom_range(1850, 13400));
                if ($urandom_range(0, 3) != 0)
                    r.day = 9'($urandom_range(1, 366));
                if ($urandom_range(0, 31) == 0)
                    r.year = '0;
                if ($urandom_range(0, 31) == 0)
                    r.day = '0;
            end
            OP_MJD2YD:
            begin
                if ($urandom_range(0, 3) == 0)
                    r.mjd = 22'($urandom_range(1, 100000));
                if ($urandom_range(0, 31) == 0)
                    r.mjd = '0;
            end
            OP_MJD2UNIX:
            begin
                if ($urandom_range(0, 3) != 0)
                    r.secs = 17'($urandom_range(1, 86399));
                if ($urandom_range(0, 3) == 0)
                    r.mjd = 22'($urandom_range(1, 100000));
                if ($urandom_range(0, 31) == 0)
                    r.mjd = '0;
                if ($urandom_range(0, 31) == 0)
                    r.secs = '0;
            end
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    r.unix = 38'($urandom);
                if ($urandom_range(0, 31) == 0)
                    r.unix = '0;
            end
        endcase
        pending_requests.push_back(r);
    endfunction

    function automatic void check_field(string name, logic [39:0] exp_v, logic [39:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Driver: a new beat goes out once the previous one was taken.
    always @(negedge clk)
    begin
        conv_req_t r;
        if (rst_n && (!start || beat_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_requests.size() != 0)
            begin
                r = pending_requests.pop_front();
                op <= r.op;
                gps_year <= r.year;
                gps_day <= r.day;
                mjd_in <= r.mjd;
                day_secs_in <= r.secs;
                unix_in <= r.unix;
                start <= 1'b1;
                issued <= issued + 1;
                if (issued < total_items - QUIET_TAIL && $urandom_range(0, 7) == 0)
                    gap_left <= $urandom_range(1, 16);
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predicts on each accepted request, checks each result beat.
    always @(posedge clk)
    begin
        conv_req_t r;
        conv_res_t e;
        if (rst_n)
        begin
            beat_taken <= start && !busy;
            if (start && !busy)
            begin
                r.op = op_t'(op);
                r.year = gps_year;
                r.day = gps_day;
                r.mjd = mjd_in;
                r.secs = day_secs_in;
                r.unix = unix_in;
                awaited_results.push_back(convert_timestamp(r));
                accepted_cnt++;
            end
            if (done)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result beat with no request outstanding", $time);
                    errors++;
                end
                else
                begin
                    e = awaited_results.pop_front();
                    check_field("valid_res", 40'(e.valid), 40'(valid_res));
                    check_field("mjd_out", 40'(e.mjd), 40'(mjd_out));
                    check_field("year_out", 40'(e.year), 40'(year_out));
                    check_field("day_out", 40'(e.day), 40'(day_out));
                    check_field("unix_out", e.unix, unix_out);
                    check_field("day_secs_out", 40'(e.secs), 40'(day_secs_out));
                end
            end
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("FAIL");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        start = 1'b0;
        op = '0;
        gps_year = '0;
        gps_day = '0;
        mjd_in = '0;
        day_secs_in = '0;
        unix_in = '0;

        // Year/day to MJD: zero operands, MJD below zero and at zero,
        // out-of-range large years, days past the end of the year.
        add_request(OP_YD2MJD, 14'd0, 9'd1, '0, '0, '0);
        add_request(OP_YD2MJD, 14'd2000, 9'd0, '0, '0, '0);
        add_request(OP_YD2MJD, 14'd1, 9'd1, '0, '0, '0);
        add_request(OP_YD2MJD, 14'd1858, 9'd320, '0, '0, '0);
        add_request(OP_YD2MJD, 14'd1858, 9'd321, '0, '0, '0);
        add_request(OP_YD2MJD, 14'd9999, 9'd366, '0, '0, '0);
        add_request(OP_YD2MJD, 14'd16383, 9'd511, '0, '0, '0);
        add_request(OP_YD2MJD, 14'd2000, 9'd511, '0, '0, '0);
        // MJD to year/day: zero, smallest, around a leap-year start, and the
        // largest MJD, in the far future.
        add_request(OP_MJD2YD, '0, '0, 22'd0, '0, '0);
        add_request(OP_MJD2YD, '0, '0, 22'd1, '0, '0);
        add_request(OP_MJD2YD, '0, '0, 22'd51543, '0, '0);
        add_request(OP_MJD2YD, '0, '0, 22'd51544, '0, '0);
        add_request(OP_MJD2YD, '0, '0, 22'd51604, '0, '0);
        add_request(OP_MJD2YD, '0, '0, 22'd4194303, '0, '0);
        // MJD plus seconds to Unix: zero operands, negative result, extremes.
        add_request(OP_MJD2UNIX, '0, '0, 22'd0, 17'd5, '0);
        add_request(OP_MJD2UNIX, '0, '0, 22'd5, 17'd0, '0);
        add_request(OP_MJD2UNIX, '0, '0, 22'd1, 17'd1, '0);
        add_request(OP_MJD2UNIX, '0, '0, 22'd40587, 17'd86399, '0);
        add_request(OP_MJD2UNIX, '0, '0, 22'd4194303, 17'd131071, '0);
        // Unix to MJD plus seconds: zero, day boundaries, largest value.
        add_request(OP_UNIX2MJD, '0, '0, '0, '0, 38'd0);
        add_request(OP_UNIX2MJD, '0, '0, '0, '0, 38'd1);
        add_request(OP_UNIX2MJD, '0, '0, '0, '0, 38'd86399);
        add_request(OP_UNIX2MJD, '0, '0, '0, '0, 38'd86400);
        add_request(OP_UNIX2MJD, '0, '0, '0, '0, {38{1'b1}});
        for (int i = 0; i < NUM_RANDOM; i++)
            add_random_request();
        total_items = pending_requests.size();

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < total_items)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
